### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCF_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define PCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### rtl/pcfwrl_pkg.sv
// ----------------------------------------------------------------------------
// pcfwrl_pkg
// Types and constants of the per-client fixed-window rate limiter.
// ----------------------------------------------------------------------------
package pcfwrl_pkg;

    localparam int CLIENT_W   = 32;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int RETRY_W    = 23;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam logic [COUNT_W-1:0] MAX_REQUESTS_RST = 16'd60;
    localparam logic [TIME_W-1:0]  WINDOW_MS_RST    = 32'd60000;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 1'd1;

    // x / 1000 == ((x >> 3) * DIV_RECIP) >> DIV_SHIFT, exact for 32-bit x
    localparam int              DIV_PRE_SHIFT = 3;
    localparam int              DIV_RECIP_W   = 30;
    localparam int              DIV_SHIFT     = 36;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 30'd549755814;
    localparam int              DIV_ARG_W     = TIME_W - DIV_PRE_SHIFT;
    localparam int              DIV_PROD_W    = DIV_ARG_W + DIV_RECIP_W;

    typedef struct packed {
        logic [CLIENT_W-1:0] client_address;
        logic [TIME_W-1:0]   now_ms;
    } req_t;

    typedef struct packed {
        logic               allowed;
        logic [RETRY_W-1:0] retry_after_s;
        logic               table_full;
    } rsp_t;

    // Token handed from cell to cell; apply=0 is the ageing/search pass.
    typedef struct packed {
        logic              active;
        logic              apply;
        logic              hit;
        logic              placed;
        logic              deny;
        logic [TIME_W-1:0] remain;
    } cell_tok_t;

endpackage

### rtl/pcfwrl_cell.sv
// ----------------------------------------------------------------------------
// pcfwrl_cell
// One table entry of the limiter chain: ages, matches and updates itself
// when the token passes, then hands the token to the next cell.
// ----------------------------------------------------------------------------
module pcfwrl_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pcfwrl_pkg::CLIENT_W-1:0]   client,
    input  logic [pcfwrl_pkg::TIME_W-1:0]     now,
    input  logic [pcfwrl_pkg::COUNT_W-1:0]    max_requests,
    input  logic [pcfwrl_pkg::TIME_W-1:0]     window_ms,
    input  pcfwrl_pkg::cell_tok_t             tok_in,
    output pcfwrl_pkg::cell_tok_t             tok_out
);

    logic                             valid_reg, valid_next;
    logic [pcfwrl_pkg::CLIENT_W-1:0]  client_reg, client_next;
    logic [pcfwrl_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [pcfwrl_pkg::TIME_W-1:0]    start_reg, start_next;
    pcfwrl_pkg::cell_tok_t            tok_reg, tok_next;

    logic [pcfwrl_pkg::TIME_W-1:0]    elapsed;
    logic                             match;

    assign elapsed = now - start_reg;
    assign match   = valid_reg && (client_reg == client);

    always_comb
    begin
        valid_next  = valid_reg;
        client_next = client_reg;
        count_next  = count_reg;
        start_next  = start_reg;
        tok_next    = tok_in;
        if (tok_in.active)
        begin
            if (!tok_in.apply)
            begin
                // drop entries whose window lies fully in the past
                if (valid_reg && (elapsed > window_ms))
                begin
                    valid_next = 1'b0;
                end
                else if (match)
                begin
                    tok_next.hit = 1'b1;
                end
            end
            else if (match)
            begin
                if (elapsed < window_ms)
                begin
                    if (count_reg >= max_requests)
                    begin
                        tok_next.deny   = 1'b1;
                        tok_next.remain = window_ms - elapsed;
                    end
                    else
                    begin
                        count_next = count_reg + 16'd1;
                    end
                end
                else
                begin
                    count_next = 16'd1;
                    start_next = now;
                end
            end
            else if (!tok_in.hit && !tok_in.placed && !valid_reg)
            begin
                // lowest free entry takes the new client
                valid_next      = 1'b1;
                client_next     = client;
                count_next      = 16'd1;
                start_next      = now;
                tok_next.placed = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        client_reg <= client_next;
        count_reg  <= count_next;
        start_reg  <= start_next;
    end

    assign tok_out = tok_reg;

endmodule

### rtl/per_client_fixed_window_rate_limiter_unit.sv
// ----------------------------------------------------------------------------
// per_client_fixed_window_rate_limiter_unit
// Per-client fixed-window request limiter over a chain of table cells.
// ----------------------------------------------------------------------------
// One request is taken at a time. A token launched on acceptance walks the
// cell chain twice, one cell per cycle, before the result is ready: the
// first walk ages entries and finds the client, the second updates the hit
// entry or places a new one in the lowest free cell; a multiply stage then
// turns the remaining window into whole seconds. A finished beat waits in
// the output register, and the next request is accepted meanwhile.
// Configuration writes take effect at once and belong in idle periods.
module per_client_fixed_window_rate_limiter_unit
#(
    parameter int TABLE_ENTRIES = pcfwrl_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  pcfwrl_pkg::req_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output pcfwrl_pkg::rsp_t                   out_data,
    input  logic                               cfg_wr_en,
    input  logic [pcfwrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcfwrl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SWEEP = 5'b00010,
        S_APPLY = 5'b00100,
        S_SCALE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                                 state_reg, state_next;
    logic                                   launch_reg, launch_next;
    logic                                   apply_reg, apply_next;
    logic                                   hit_reg, hit_next;
    logic                                   out_valid_reg, out_valid_next;

    logic [pcfwrl_pkg::COUNT_W-1:0]         max_requests_reg;
    logic [pcfwrl_pkg::TIME_W-1:0]          window_ms_reg;

    pcfwrl_pkg::req_t                       req_reg;
    logic                                   allowed_reg;
    logic                                   full_reg;
    logic [pcfwrl_pkg::TIME_W-1:0]          remain_reg;
    logic [pcfwrl_pkg::DIV_PROD_W-1:0]      prod_reg;
    pcfwrl_pkg::rsp_t                       out_data_reg;

    pcfwrl_pkg::cell_tok_t                  tok_chain [TABLE_ENTRIES+1];
    pcfwrl_pkg::cell_tok_t                  tok_last;
    logic                                   accept;
    logic                                   load_out;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign tok_last = tok_chain[TABLE_ENTRIES];
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign tok_chain[0] = '{active: launch_reg, apply: apply_reg, hit: hit_reg,
                            default: '0};

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++)
    begin : g_cell
        pcfwrl_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .client       (req_reg.client_address),
            .now          (req_reg.now_ms),
            .max_requests (max_requests_reg),
            .window_ms    (window_ms_reg),
            .tok_in       (tok_chain[gi]),
            .tok_out      (tok_chain[gi+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        apply_next     = apply_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    launch_next = 1'b1;
                    apply_next  = 1'b0;
                    hit_next    = 1'b0;
                    state_next  = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (tok_last.active)
                begin
                    // relaunch with the search outcome for the update walk
                    launch_next = 1'b1;
                    apply_next  = 1'b1;
                    hit_next    = tok_last.hit;
                    state_next  = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (tok_last.active)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            launch_reg       <= 1'b0;
            apply_reg        <= 1'b0;
            hit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            max_requests_reg <= pcfwrl_pkg::MAX_REQUESTS_RST;
            window_ms_reg    <= pcfwrl_pkg::WINDOW_MS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            apply_reg     <= apply_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    pcfwrl_pkg::REG_MAX_REQUESTS:
                        max_requests_reg <= cfg_data[pcfwrl_pkg::COUNT_W-1:0];
                    pcfwrl_pkg::REG_WINDOW_MS:
                        window_ms_reg <= cfg_data[pcfwrl_pkg::TIME_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
        if ((state_reg == S_APPLY) && tok_last.active)
        begin
            allowed_reg <= !tok_last.deny;
            full_reg    <= !tok_last.hit && !tok_last.placed;
            remain_reg  <= tok_last.remain;
        end
        if (state_reg == S_SCALE)
        begin
            prod_reg <= pcfwrl_pkg::DIV_PROD_W'(
                            remain_reg[pcfwrl_pkg::TIME_W-1:pcfwrl_pkg::DIV_PRE_SHIFT])
                        * pcfwrl_pkg::DIV_PROD_W'(pcfwrl_pkg::DIV_RECIP);
        end
        if (load_out)
        begin
            out_data_reg.allowed       <= allowed_reg;
            out_data_reg.retry_after_s <=
                prod_reg[pcfwrl_pkg::DIV_SHIFT +: pcfwrl_pkg::RETRY_W];
            out_data_reg.table_full    <= full_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/pcfwrl_checker.sv
// ----------------------------------------------------------------------------
// pcfwrl_checker
// Port-level checks of the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcfwrl_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  pcfwrl_pkg::rsp_t                   out_data
);

    // a stalled result beat holds
    `PCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // one request in flight: no second beat right after an accept
    `PCF_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // only denied beats carry a retry time
    `PCF_ASSERT(a_retry_zero, clk, rst_n, out_valid && out_data.allowed, out_data.retry_after_s == '0)

    // an untracked new client is never denied
    `PCF_ASSERT(a_full_allows, clk, rst_n, out_valid && out_data.table_full, out_data.allowed)

endmodule

bind per_client_fixed_window_rate_limiter_unit pcfwrl_checker u_pcfwrl_checker (.*);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-client fixed-window rate limiter. A short
// table of requests and register settings comes first: window ageing, the
// elapsed-equals-window restart, denial with retry seconds, zero limit,
// zero window and a full client table. Random phases follow, each with its
// own limit, window, time step and client pool. Every request is run
// through a local model of the client table, and each response beat is
// compared field by field with the oldest pending verdict.
// ----------------------------------------------------------------------------
module tb;

    import pcfwrl_pkg::*;

    localparam int SLOTS       = TABLE_ENTRIES_DEF;
    localparam int LATENCY     = 2 * SLOTS + 4;
    localparam int MS_PER_SEC  = 1000;
    localparam int PHASE_ITEMS = 200;
    localparam int PHASES      = 9;
    localparam int POOL_MAX    = 24;

    typedef struct {
        bit                is_cfg;
        logic [31:0]       max_word;
        logic [TIME_W-1:0] win;
        req_t              req;
        bit                typed;
        rsp_t              want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    req_t                  in_data;
    logic                  out_valid;
    logic                  out_ready;
    rsp_t                  out_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // local copy of the client table and limits
    logic [COUNT_W-1:0]    lim_max;
    logic [TIME_W-1:0]     lim_window;
    logic                  slot_live   [SLOTS];
    logic [CLIENT_W-1:0]   slot_client [SLOTS];
    logic [COUNT_W-1:0]    slot_count  [SLOTS];
    logic [TIME_W-1:0]     slot_start  [SLOTS];

    rsp_t                  verdict_q[$];
    dir_row_t              dir_rows[$];
    int                    mismatches;
    int                    send_idle_pct;
    int                    recv_stall_pct;

    per_client_fixed_window_rate_limiter_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #1_200_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic flag_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Age the table, look up the client and return the verdict.
    function automatic rsp_t rate_verdict(req_t r);
        rsp_t              v;
        int                i;
        int                hit;
        int                free_slot;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] secs;
        v = '0;
        v.allowed = 1'b1;
        hit = -1;
        free_slot = -1;
        for (i = 0; i < SLOTS; i++)
        begin
            age = r.now_ms - slot_start[i];
            if (slot_live[i] && age > lim_window)
                slot_live[i] = 1'b0;
        end
        for (i = 0; i < SLOTS; i++)
        begin
            if (slot_live[i])
            begin
                if (hit < 0 && slot_client[i] == r.client_address)
                    hit = i;
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end
        if (hit >= 0)
        begin
            age = r.now_ms - slot_start[hit];
            if (age < lim_window)
            begin
                if (slot_count[hit] >= lim_max)
                begin
                    secs = (lim_window - age) / MS_PER_SEC;
                    v.allowed = 1'b0;
                    v.retry_after_s = secs[RETRY_W-1:0];
                end
                else
                begin
                    slot_count[hit] = slot_count[hit] + 1'b1;
                end
            end
            else
            begin
                slot_count[hit] = 16'd1;
                slot_start[hit] = r.now_ms;
            end
        end
        else if (free_slot >= 0)
        begin
            slot_live[free_slot]   = 1'b1;
            slot_client[free_slot] = r.client_address;
            slot_count[free_slot]  = 16'd1;
            slot_start[free_slot]  = r.now_ms;
        end
        else
        begin
            v.table_full = 1'b1;
        end
        return v;
    endfunction

    // Write both registers once the block has drained.
    task automatic set_config(logic [31:0] max_word, logic [TIME_W-1:0] win);
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAX_REQUESTS;
        cfg_data  <= max_word;
        @(posedge clk);
        cfg_index <= REG_WINDOW_MS;
        cfg_data  <= win;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lim_max    = max_word[COUNT_W-1:0];
        lim_window = win;
    endtask

    // Hold the beat until accepted, then record the verdict it must produce.
    task automatic send_request(req_t r, bit typed, rsp_t want);
        rsp_t v;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        v = rate_verdict(r);
        verdict_q.push_back(typed ? want : v);
    endtask

    task automatic add_req(logic [31:0] client, logic [31:0] stamp);
        dir_row_t row;
        row = '{default: '0};
        row.req.client_address = client;
        row.req.now_ms = stamp;
        dir_rows.push_back(row);
    endtask

    task automatic add_typed(logic [31:0] client, logic [31:0] stamp,
                             logic ok, logic [RETRY_W-1:0] secs, logic full);
        dir_row_t row;
        row = '{default: '0};
        row.req.client_address = client;
        row.req.now_ms = stamp;
        row.typed = 1'b1;
        row.want.allowed = ok;
        row.want.retry_after_s = secs;
        row.want.table_full = full;
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(logic [31:0] max_word, logic [31:0] win);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.max_word = max_word;
        row.win = win;
        dir_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                flag_mismatch("response beat with no verdict pending");
            end
            else
            begin
                want = verdict_q.pop_front();
                if (out_data.allowed !== want.allowed)
                    flag_mismatch($sformatf("allowed got %0b exp %0b",
                                            out_data.allowed, want.allowed));
                if (out_data.retry_after_s !== want.retry_after_s)
                    flag_mismatch($sformatf("retry_after_s got %0d exp %0d",
                                            out_data.retry_after_s, want.retry_after_s));
                if (out_data.table_full !== want.table_full)
                    flag_mismatch($sformatf("table_full got %0b exp %0b",
                                            out_data.table_full, want.table_full));
            end
        end
    end

    initial
    begin : main
        int                  i;
        int                  p;
        int                  n;
        int                  pick;
        int                  roll;
        int                  pool_n;
        logic [31:0]         max_word;
        logic [TIME_W-1:0]   win;
        logic [TIME_W-1:0]   step_max;
        logic [TIME_W-1:0]   clock_ms;
        logic [CLIENT_W-1:0] client_pool [POOL_MAX];
        req_t                r;
        rsp_t                none;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_MAX_REQUESTS;
        cfg_data       = '0;
        mismatches     = 0;
        send_idle_pct  = 7;
        recv_stall_pct = 61;
        none           = '0;
        lim_max        = MAX_REQUESTS_RST;
        lim_window     = WINDOW_MS_RST;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_live[i]   = 1'b0;
            slot_client[i] = '0;
            slot_count[i]  = '0;
            slot_start[i]  = '0;
        end

        // reset defaults, ageing across wrap, elapsed equal to window
        add_typed(32'h0000_0000, 32'h0000_0000, 1'b1, '0, 1'b0);
        add_typed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0, 1'b0);
        add_cfg(32'hABCD_0001, 32'd60000);
        add_typed(32'h0000_0000, 32'd10, 1'b1, '0, 1'b0);
        add_typed(32'h0000_0000, 32'd20, 1'b0, 23'd59, 1'b0);
        add_typed(32'h0000_0000, 32'd60010, 1'b1, '0, 1'b0);
        // widest window gives the largest retry
        add_cfg(32'h0000_0001, 32'hFFFF_FFFF);
        add_req(32'h0000_0005, 32'd0);
        add_typed(32'h0000_0005, 32'd1, 1'b0, 23'd4294967, 1'b0);
        // zero limit: tracked client denied, new client still passes
        add_cfg(32'hFFFF_0000, 32'hFFFF_FFFF);
        add_req(32'h0000_0005, 32'd2);
        add_typed(32'h1234_5678, 32'd3, 1'b1, '0, 1'b0);
        // zero window: entries age once time moves on, nothing stays open
        add_cfg(32'h1234_0004, 32'd0);
        add_req(32'h0000_0005, 32'd4);
        add_req(32'h0000_0005, 32'd4);
        // fill the table, then one more client
        add_cfg(32'h0000_FFFF, 32'd60000);
        for (i = 0; i < SLOTS; i++)
            add_req(32'hC0A8_0000 + i, 32'h8000_0000 + i);
        add_typed(32'hC0A8_00FF, 32'h8000_0010, 1'b1, '0, 1'b1);
        add_req(32'hC0A8_0000, 32'h8000_0011);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].is_cfg)
                set_config(dir_rows[k].max_word, dir_rows[k].win);
            else
                send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            clock_ms = $urandom;
            case (p)
                0: begin max_word = 3;     win = 2000;         step_max = 150;  pool_n = 20; end
                1: begin max_word = 1;     win = 1;            step_max = 2;    pool_n = 20; end
                2: begin max_word = 2;     win = 32'hFFFF_FFFF;
                         step_max = 32'h00FF_FFFF;                              pool_n = 24; end
                3: begin max_word = 2;     win = 500;          step_max = 40;   pool_n = 12; end
                4:
                begin
                    max_word = ($urandom & 32'hFFFF_0000) | $urandom_range(8, 1);
                    win      = $urandom_range(20000, 100);
                    step_max = win / 10;
                    pool_n   = 18;
                end
                5: begin max_word = 0;     win = 3000;         step_max = 200;  pool_n = 10; end
                6: begin max_word = 4;     win = 0;            step_max = 3;    pool_n = 10; end
                7:
                begin
                    max_word = 10;
                    win      = 65536;
                    step_max = 4096;
                    pool_n   = 20;
                    clock_ms = 32'hFFFF_F000;
                end
                default:
                begin
                    max_word = ($urandom & 32'hFFFF_0000) | $urandom_range(6, 1);
                    win      = $urandom_range(5000, 1);
                    step_max = win / 8 + 1;
                    pool_n   = 16;
                end
            endcase
            set_config(max_word, win);
            send_idle_pct  = (p < 3) ? 7 : (p < 6) ? 61 : 0;
            recv_stall_pct = (p < 3) ? 61 : (p < 6) ? 7 : 0;
            for (i = 0; i < pool_n; i++)
                client_pool[i] = $urandom;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 45)
                    r.client_address = client_pool[$urandom_range(2)];
                else if (roll < 95)
                    r.client_address = client_pool[$urandom_range(pool_n - 1)];
                else
                    r.client_address = $urandom;

                roll = $urandom_range(99);
                pick = $urandom_range(SLOTS - 1);
                if (roll < 4 && slot_live[pick])
                begin
                    // land exactly on the window end of a tracked client
                    clock_ms = slot_start[pick] + lim_window;
                    r.client_address = slot_client[pick];
                end
                else if (roll < 8)
                begin
                    clock_ms = $urandom;
                end
                else
                begin
                    clock_ms = clock_ms + $urandom_range(step_max);
                end
                r.now_ms = clock_ms;
                send_request(r, 1'b0, none);
            end
        end

        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (3 * LATENCY) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
